// ===== design/lalu_pkg.sv =====
package lalu_pkg;

    localparam int MAX_W = 32;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_ADDS = 4'd1;
    localparam logic [3:0] MODE_SUB  = 4'd2;
    localparam logic [3:0] MODE_SUBS = 4'd3;
    localparam logic [3:0] MODE_MUL  = 4'd4;
    localparam logic [3:0] MODE_MULS = 4'd5;
    localparam logic [3:0] MODE_SHL  = 4'd6;
    localparam logic [3:0] MODE_SHR  = 4'd7;
    localparam logic [3:0] MODE_NORM = 4'd8;
    localparam logic [3:0] MODE_DIV  = 4'd9;

    // One operation in flight; acc holds the double word being worked on.
    typedef struct packed {
        logic [3:0]           mode;
        logic [MAX_W-1:0]     a;
        logic [MAX_W-1:0]     b;
        logic [MAX_W-1:0]     c;
        logic [2*MAX_W-1:0]   acc;
        logic [6:0]           cnt;
        logic                 flag;
    } lalu_item_t;

endpackage

// ===== design/lalu_cell.sv =====
module lalu_cell
    import lalu_pkg::*;
#(
    parameter int W   = 32,
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       prev_valid,
    input  lalu_item_t prev_data,
    output logic       cell_valid,
    output lalu_item_t cell_data
);

    localparam int DW  = 2 * W;
    localparam int LOG = $clog2(DW);
    localparam int SH  = (IDX < LOG) ? (1 << IDX) : 0;
    localparam int NS  = (IDX < LOG) ? (1 << (LOG - 1 - IDX)) : 1;

    logic       valid_reg;
    lalu_item_t data_reg;
    lalu_item_t data_next;
    logic [DW-1:0] v;
    logic [W:0]    rem;
    logic          ge;

    always_comb
    begin
        data_next = prev_data;
        v = prev_data.acc[DW-1:0];
        rem = {prev_data.acc[DW-1:W], prev_data.acc[W-1]};
        ge = (rem >= {1'b0, prev_data.c[W-1:0]});
        case (prev_data.mode)
            MODE_MUL, MODE_MULS:
            begin
                if (prev_data.b[IDX])
                begin
                    v = v + (DW'(prev_data.a[W-1:0]) << IDX);
                end
            end
            MODE_SHL:
            begin
                if (IDX < LOG && prev_data.c[IDX])
                begin
                    v = v << SH;
                end
            end
            MODE_SHR:
            begin
                if (IDX < LOG && prev_data.c[IDX])
                begin
                    v = v >> SH;
                end
            end
            MODE_NORM:
            begin
                if (IDX < LOG && v[DW-1 -: NS] == '0)
                begin
                    v = v << NS;
                    data_next.cnt = prev_data.cnt + 7'(NS);
                end
            end
            MODE_DIV:
            begin
                // One restoring step: the low half collects quotient bits.
                if (!prev_data.flag)
                begin
                    if (ge)
                    begin
                        v = {W'(rem - {1'b0, prev_data.c[W-1:0]}),
                             prev_data.acc[W-2:0], 1'b1};
                    end
                    else
                    begin
                        v = {rem[W-1:0], prev_data.acc[W-2:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
        data_next.acc = (2*MAX_W)'(v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_data  = data_reg;

endmodule

// ===== design/long_arithmetic_alu_unit.sv =====
// Long-arithmetic unit: add/sub with carry, multiply-accumulate into a
// double word, double-word shifts, normalize, and double-by-single divide.
// The input channel (in_valid/in_stall) carries mode and three operands;
// the output channel (out_valid/out_stall) carries the low and high result
// words, the overflow or divide-error flag and the normalize count.
// Every transfer in produces exactly one transfer out, in order.
// The pipeline has one entry stage that forms the working double word
// (and finishes add and subtract), one cell per word bit, and an output
// register. The chain has a cell for every word bit, since the divide
// retires one quotient bit and the multiply one partial product per cell.
// Throughput is one transfer per cycle while the output is not stalled.
// When the receiver stalls a waiting result, the whole chain holds and
// in_stall is raised in the same cycle; it drops as soon as the result
// is taken. Reset clears all valid bits, so the unit comes up empty.
module long_arithmetic_alu_unit
    import lalu_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  mode,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] operand_c,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_lo,
    output logic [31:0] result_hi,
    output logic        overflow,
    output logic [6:0]  shift_count
);

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * W;

    // The pipeline moves as one; it holds only while a result waits.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
    logic [W:0]   sum;
    logic [W:0]   dif;
    logic [DW-1:0] start;
    lalu_item_t   entry;

    // Entry: mask operands to the word width and seed the working word.
    always_comb
    begin
        am = operand_a[W-1:0];
        bm = operand_b[W-1:0];
        cm = operand_c[W-1:0];
        sum = {1'b0, am} + {1'b0, bm} + (W+1)'(cm[0]);
        dif = {1'b0, am} - {1'b0, bm} - (W+1)'(cm[0]);
        start = '0;
        entry.mode = mode;
        entry.a = MAX_W'(am);
        entry.b = MAX_W'(bm);
        entry.c = MAX_W'(cm);
        entry.cnt = '0;
        entry.flag = 1'b0;
        case (mode)
            MODE_ADD:
            begin
                start = {(W-1)'(0), sum};
            end
            MODE_ADDS:
            begin
                start = DW'(sum[W-1:0]);
                entry.flag = (am[W-1] ^ sum[W-1]) & (bm[W-1] ^ sum[W-1]);
            end
            MODE_SUB:
            begin
                start = {(W-1)'(0), dif};
            end
            MODE_SUBS:
            begin
                start = DW'(dif[W-1:0]);
                entry.flag = (am[W-1] ^ bm[W-1]) & (am[W-1] ^ dif[W-1]);
            end
            MODE_MUL, MODE_MULS:
            begin
                start = DW'(cm);
            end
            MODE_SHL, MODE_SHR:
            begin
                // Counts of a double word or more clear the result.
                start = (cm >= W'(DW)) ? '0 : {am, bm};
            end
            MODE_NORM:
            begin
                start = {am, bm};
            end
            MODE_DIV:
            begin
                entry.flag = (am >= cm);
                start = (am >= cm) ? '0 : {am, bm};
            end
            default:
            begin
            end
        endcase
        entry.acc = (2*MAX_W)'(start);
    end

    logic       chain_valid [0:W];
    lalu_item_t chain_data  [0:W];
    logic       front_valid_reg;
    lalu_item_t front_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_data_reg <= entry;
        end
    end

    assign chain_valid[0] = front_valid_reg;
    assign chain_data[0]  = front_data_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        lalu_cell #(
            .W   (W),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (chain_valid[i]),
            .prev_data  (chain_data[i]),
            .cell_valid (chain_valid[i+1]),
            .cell_data  (chain_data[i+1])
        );
    end

    // Output formatting: the signed multiply check and the zero normalize
    // case are settled here from the finished double word.
    lalu_item_t   last;
    logic [W-1:0] lo_w;
    logic [W-1:0] hi_w;
    logic         ovf_w;
    logic [6:0]   cnt_w;

    always_comb
    begin
        last = chain_data[W];
        lo_w = last.acc[W-1:0];
        hi_w = last.acc[DW-1:W];
        ovf_w = last.flag | ((last.mode == MODE_MULS) && (hi_w != {W{lo_w[W-1]}}));
        cnt_w = ((last.mode == MODE_NORM) && (last.acc[DW-1:0] == '0)) ? 7'(DW)
                                                                      : last.cnt;
    end

    logic        out_valid_reg;
    logic [31:0] result_lo_reg;
    logic [31:0] result_hi_reg;
    logic        overflow_reg;
    logic [6:0]  shift_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_lo_reg   <= 32'(lo_w);
            result_hi_reg   <= 32'(hi_w);
            overflow_reg    <= ovf_w;
            shift_count_reg <= cnt_w;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_lo   = result_lo_reg;
    assign result_hi   = result_hi_reg;
    assign overflow    = overflow_reg;
    assign shift_count = shift_count_reg;

`ifndef SYNTHESIS
    // The input is held off exactly when a finished result is stalled.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output stall");

    // A partial normalize count always leaves the top bit set.
    a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shift_count != 7'd0 && shift_count != 7'(DW))
            |-> result_hi[W-1])
        else $error("normalize result not left-justified");

    // A full count only comes from a zero word.
    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shift_count == 7'(DW)) |-> (result_lo == 32'd0 && result_hi == 32'd0))
        else $error("full normalize count with nonzero result");
`endif

endmodule
